[hw/rtl/fre_pkg.sv]
// shared constants for the frame rate estimator
// no dependencies; imported by fre_div and frame_rate_estimator_top
package fre_pkg;

    localparam int RATE_W     = 32;  // Q16.16 rate width
    localparam int TIME_IN_W  = 32;  // timestamp port width
    localparam int WEIGHT_W   = 17;  // Q1.16 weight, one included
    localparam int WEIGHT_FRAC = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int US_W       = 20;  // bits of one million
    localparam int US_PER_SEC = 1000000;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING    = CFG_IDX_W'(1);

    // update_status codes
    localparam logic [1:0] STAT_FIRST    = 2'd0;
    localparam logic [1:0] STAT_UPDATED  = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;

endpackage

[hw/rtl/fre_div.sv]
// bit-serial restoring divider: (1e6 << RATE_FRAC_BITS) / dt, saturated to the rate width
// depends on fre_pkg
module fre_div #(
    parameter int TIME_WIDTH     = 32,
    parameter int RATE_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [TIME_WIDTH-1:0]     i_dt,
    output logic                      o_done,
    output logic [fre_pkg::RATE_W-1:0] o_quotient
);
    import fre_pkg::*;

    localparam int NUM_W = US_W + RATE_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] NUMERATOR = NUM_W'(US_PER_SEC) << RATE_FRAC_BITS;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [NUM_W-1:0]      r_num;
    logic [TIME_WIDTH-1:0] r_dt;
    logic [TIME_WIDTH-1:0] r_rem;
    logic [RATE_W-1:0]     r_quo;
    logic                  r_sat;

    logic [TIME_WIDTH:0]   rem_sh;
    logic [TIME_WIDTH:0]   rem_sub;
    logic                  q_bit;
    logic [TIME_WIDTH-1:0] n_rem;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_dt};
        q_bit   = (rem_sh >= {1'b0, r_dt});
        n_rem   = q_bit ? rem_sub[TIME_WIDTH-1:0] : rem_sh[TIME_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUMERATOR;
            r_dt  <= i_dt;
            r_rem <= '0;
            r_quo <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[RATE_W-2:0], q_bit};
            // any quotient bit pushed past the top means saturation
            r_sat <= r_sat | r_quo[RATE_W-1];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_sat ? '1 : r_quo;

`ifndef SYNTH
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a run");
    a_rem_below_dt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_rem < r_dt)
        else $error("divider remainder not below divisor");
`endif

endmodule

[hw/rtl/frame_rate_estimator_top.sv]
// frame rate estimator top level: handshakes, config registers, outlier test, blend
// depends on fre_pkg and fre_div
//
// Each accepted frame_time yields one result. The first frame after reset loads the
// estimate from initial_rate and goes straight to its result; a repeated timestamp is
// rejected the same way. Any other frame runs the bit-serial divider (one quotient bit
// per cycle), then picks up the quotient and runs the outlier test, then does a
// bit-serial weight multiply, rounding and result load. An outlier leaves after the
// test. One frame is in work at a time; the next is taken once the result sits in the
// output register.
module frame_rate_estimator_top #(
    parameter int TIME_WIDTH     = 32,
    parameter int RATE_FRAC_BITS = 16,
    parameter int OUTLIER_FACTOR = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [fre_pkg::TIME_IN_W-1:0]   i_frame_time,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fre_pkg::RATE_W-1:0]      o_rate_estimate,
    output logic [1:0]                      o_update_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fre_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fre_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fre_pkg::*;

    localparam int FACT_W = $clog2(OUTLIER_FACTOR + 1);
    localparam int PROD_W = RATE_W + FACT_W;
    localparam int ACC_W  = RATE_W + 1 + WEIGHT_W;
    localparam int MCNT_W = $clog2(WEIGHT_W + 1);
    localparam logic [PROD_W-1:0] FACTOR = PROD_W'(OUTLIER_FACTOR);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (WEIGHT_FRAC - 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIVIDE = 7'b0000010,
        S_SCALE  = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_ROUND  = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state                   r_state;
    logic                     r_have;
    logic [TIME_WIDTH-1:0]    r_prev;
    logic [RATE_W-1:0]        r_rate;
    logic [RATE_W-1:0]        r_init;
    logic [WEIGHT_W-1:0]      r_weight;
    logic [RATE_W-1:0]        r_fresh;
    logic [PROD_W-1:0]        r_lo;
    logic [PROD_W-1:0]        r_hi;
    logic signed [RATE_W:0]   r_diff;
    logic signed [ACC_W-1:0]  r_acc;
    logic [WEIGHT_W-1:0]      r_wsh;
    logic [MCNT_W-1:0]        r_mcnt;
    logic [1:0]               r_status;
    logic                     r_out_valid;
    logic [RATE_W-1:0]        r_out_rate;
    logic [1:0]               r_out_status;

    logic                     in_acc;
    logic                     out_free;
    logic [TIME_WIDTH-1:0]    now;
    logic [TIME_WIDTH-1:0]    dt;
    logic                     div_start;
    logic                     div_done;
    logic [RATE_W-1:0]        div_quo;
    logic [WEIGHT_W-1:0]      w_sat;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  blend_sum;
    logic                     inside_band;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        now       = TIME_WIDTH'(i_frame_time);
        dt        = now - r_prev;
        div_start = in_acc && r_have && (dt != '0);
        w_sat     = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;
        // msb-first shift-add of weight times (fresh - old)
        n_acc     = (r_acc <<< 1) + (r_wsh[WEIGHT_W-1] ? ACC_W'(r_diff) : '0);
        blend_sum = $signed({(ACC_W-RATE_W-WEIGHT_FRAC)'(0), r_rate, WEIGHT_FRAC'(0)})
                    + r_acc + HALF;
        inside_band = (r_lo > PROD_W'(r_rate)) && (PROD_W'(r_fresh) < r_hi);
    end

    fre_div #(
        .TIME_WIDTH     (TIME_WIDTH),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dt       (dt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= RATE_W'(655360);
            r_weight <= WEIGHT_W'(3277);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_INITIAL_RATE: r_init   <= i_cfg_data[RATE_W-1:0];
                REG_SMOOTHING:    r_weight <= i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_prev      <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_prev <= now;
                        if (!r_have) begin
                            r_have   <= 1'b1;
                            r_rate   <= r_init;
                            r_status <= STAT_FIRST;
                            r_state  <= S_EMIT;
                        end else if (dt == '0) begin
                            r_status <= STAT_REJECTED;
                            r_state  <= S_EMIT;
                        end else begin
                            r_state <= S_DIVIDE;
                        end
                    end
                end
                S_DIVIDE: begin
                    if (div_done) begin
                        r_fresh <= div_quo;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_lo    <= PROD_W'(r_fresh) * FACTOR;
                    r_hi    <= PROD_W'(r_rate) * FACTOR;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (inside_band) begin
                        r_diff  <= $signed({1'b0, r_fresh}) - $signed({1'b0, r_rate});
                        r_acc   <= '0;
                        r_wsh   <= w_sat;
                        r_mcnt  <= MCNT_W'(WEIGHT_W);
                        r_state <= S_MUL;
                    end else begin
                        r_status <= STAT_REJECTED;
                        r_state  <= S_EMIT;
                    end
                end
                S_MUL: begin
                    r_acc  <= n_acc;
                    r_wsh  <= {r_wsh[WEIGHT_W-2:0], 1'b0};
                    r_mcnt <= r_mcnt - MCNT_W'(1);
                    if (r_mcnt == MCNT_W'(1)) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_rate   <= blend_sum[WEIGHT_FRAC +: RATE_W];
                    r_status <= STAT_UPDATED;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_rate   <= r_rate;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rate_estimate = r_out_rate;
    assign o_update_status = r_out_status;

`ifndef SYNTH
    a_have_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_have))
        else $error("first-frame flag cleared outside reset");
    a_div_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIVIDE)
        else $error("divider finished outside the divide state");
    a_rate_held_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && !inside_band) |=> $stable(r_rate))
        else $error("estimate changed on a rejected sample");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_update_status == STAT_FIRST || o_update_status == STAT_UPDATED
                         || o_update_status == STAT_REJECTED))
        else $error("bad update status code");
`endif

endmodule
